FILE: design/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

	localparam int VALUE_W        = 32;
	localparam int DIGIT_W        = 4;
	localparam int CHAR_W         = 8;
	localparam int STAGE_BITS     = 8;
	localparam int MAX_DIGITS_DEF = 10;

	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'h39;
	localparam logic [DIGIT_W-1:0] DD_THRESH   = 4'd5;
	localparam logic [DIGIT_W-1:0] DD_ADJ      = 4'd3;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_signed;
	} in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} out_t;

endpackage

`default_nettype wire

FILE: design/b2da_dabble.sv
// ----------------------------------------------------------------------------
// b2da_dabble
// Pipelined shift-add-3 binary to BCD conversion, STAGE_BITS bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_dabble
	import b2da_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            up_valid,
	output      logic                            up_ready,
	input  wire logic [VALUE_W-1:0]              up_bin,
	input  wire logic                            up_neg,
	output      logic                            dn_valid,
	input  wire logic                            dn_ready,
	output      logic [MAX_DIGITS*DIGIT_W-1:0]   dn_bcd,
	output      logic                            dn_neg
);

	localparam int BCD_W = MAX_DIGITS * DIGIT_W;
	localparam int NS    = VALUE_W / STAGE_BITS;

	logic [NS-1:0]             valid_s;
	logic [BCD_W-1:0]          bcd_s [NS];
	logic [VALUE_W-1:0]        bin_s [NS];
	logic [NS-1:0]             neg_s;

	logic [NS:0]               rdy;
	logic [BCD_W-1:0]          nxt_bcd [NS];
	logic [VALUE_W-1:0]        nxt_bin [NS];

	assign rdy[NS] = dn_ready;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic               in_valid;
		logic [BCD_W-1:0]   in_bcd;
		logic [VALUE_W-1:0] in_bin;
		logic               in_neg;

		if (k == 0) begin : g_first
			assign in_valid = up_valid;
			assign in_bcd   = '0;
			assign in_bin   = up_bin;
			assign in_neg   = up_neg;
		end else begin : g_next
			assign in_valid = valid_s[k-1];
			assign in_bcd   = bcd_s[k-1];
			assign in_bin   = bin_s[k-1];
			assign in_neg   = neg_s[k-1];
		end

		assign rdy[k] = !valid_s[k] || rdy[k+1];

		always_comb begin
			logic [BCD_W-1:0]   b;
			logic [VALUE_W-1:0] r;
			b = in_bcd;
			r = in_bin;
			for (int s = 0; s < STAGE_BITS; s++) begin
				for (int d = 0; d < MAX_DIGITS; d++) begin
					if (b[d*DIGIT_W +: DIGIT_W] >= DD_THRESH) begin
						b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + DD_ADJ;
					end
				end
				b = {b[BCD_W-2:0], r[VALUE_W-1]};
				r = {r[VALUE_W-2:0], 1'b0};
			end
			nxt_bcd[k] = b;
			nxt_bin[k] = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				valid_s[k] <= in_valid;
			end
		end

		// advance payload only on a transfer into this stage
		always_ff @(posedge clk) begin
			if (rdy[k] && in_valid) begin
				bcd_s[k] <= nxt_bcd[k];
				bin_s[k] <= nxt_bin[k];
				neg_s[k] <= in_neg;
			end
		end
	end

	assign up_ready = rdy[0];
	assign dn_valid = valid_s[NS-1];
	assign dn_bcd   = bcd_s[NS-1];
	assign dn_neg   = neg_s[NS-1];

endmodule

`default_nettype wire

FILE: design/b2da_serial.sv
// ----------------------------------------------------------------------------
// b2da_serial
// Serializer: sign if negative, significant digits, one per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_serial
	import b2da_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          up_valid,
	output      logic                          up_ready,
	input  wire logic [MAX_DIGITS*DIGIT_W-1:0] up_bcd,
	input  wire logic                          up_neg,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      out_t                          out_data
);

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] up_digits;
	logic                               busy_q;
	logic                               sign_q;
	logic [IDX_W-1:0]                   idx_q;
	logic                               out_valid_q;
	out_t                               out_data_q;

	logic [IDX_W-1:0]  top;
	logic              load;
	logic              emit;
	logic              emit_last;
	logic [CHAR_W-1:0] ch;

	assign up_digits = up_bcd;

	// highest nonzero digit; zero keeps the ones digit
	always_comb begin
		top = '0;
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (up_digits[d] != '0) begin
				top = IDX_W'(d);
			end
		end
	end

	assign up_ready  = !busy_q;
	assign load      = up_valid && !busy_q;
	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign emit_last = !sign_q && (idx_q == '0);
	assign ch        = sign_q ? ASCII_MINUS
	                          : (ASCII_ZERO | {{(CHAR_W-DIGIT_W){1'b0}}, digits_q[idx_q]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && emit_last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= up_digits;
			sign_q   <= up_neg;
			idx_q    <= top;
		end else if (emit) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
		end
		if (emit) begin
			out_data_q.character <= ch;
			out_data_q.last      <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

FILE: design/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// 32-bit binary to decimal ASCII text, one character per output transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries a 32-bit value and a signed flag; the block
// returns its decimal text most significant digit first, with a leading '-'
// for a negative signed value, no leading zeros, "0" for zero, and last set
// on the final character. The value passes a negate stage and four
// shift-add-3 stages (8 bits each), then the serializer's load and output
// registers. The character serializer sets the rate: it takes one value,
// then emits its n characters (1 to 11) one per cycle when the output is not
// stalled, and takes no new value until it has emitted the last of them.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii
	import b2da_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output      logic in_ready,
	input  wire in_t  in_data,
	output      logic out_valid,
	input  wire logic out_ready,
	output      out_t out_data
);

	logic               valid_s1;
	logic [VALUE_W-1:0] mag_s1;
	logic               neg_s1;

	logic                          dd_ready;
	logic                          dd_valid;
	logic [MAX_DIGITS*DIGIT_W-1:0] dd_bcd;
	logic                          dd_neg;
	logic                          ser_ready;
	logic                          in_neg;

	assign in_ready = !valid_s1 || dd_ready;
	assign in_neg   = in_data.is_signed && in_data.value[VALUE_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// negate to magnitude; the most negative value wraps to 2^31 unsigned
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mag_s1 <= in_neg ? (VALUE_W'(0) - in_data.value) : in_data.value;
			neg_s1 <= in_neg;
		end
	end

	b2da_dabble #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_dabble (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s1),
		.up_ready (dd_ready),
		.up_bin   (mag_s1),
		.up_neg   (neg_s1),
		.dn_valid (dd_valid),
		.dn_ready (ser_ready),
		.dn_bcd   (dd_bcd),
		.dn_neg   (dd_neg)
	);

	b2da_serial #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (dd_valid),
		.up_ready  (ser_ready),
		.up_bcd    (dd_bcd),
		.up_neg    (dd_neg),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.character == ASCII_MINUS) |-> !out_data.last)
		else $error("minus sign marked as last character");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.character == ASCII_MINUS) ||
		((out_data.character >= ASCII_ZERO) && (out_data.character <= ASCII_NINE)))
		else $error("character is neither a digit nor a minus sign");

	a_s1_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("input transfer did not load the negate stage");

endmodule

`default_nettype wire
